/* hdl/bfs_pkg.sv */
// Shared types, constants and helpers for the bitmap find-first-set block.
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

  localparam int WORD_BITS = 32;
  localparam int POS_W = 5;
  localparam int WORD_IDX_W = 5;
  localparam int IDX_W = WORD_IDX_W + POS_W;
  localparam int ACT_W = 3;
  localparam int WIU_W = 6;
  localparam int ADDRESSABLE_WORDS = 32;
  localparam int DEFAULT_WORD_COUNT = 32;
  localparam logic [WIU_W-1:0] WIU_RESET = 6'd32;
  localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // Action codes carried in the input word
  typedef enum logic [ACT_W-1:0] {
    ACT_GET       = 3'd0,
    ACT_SET       = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_SET_ALL   = 3'd3,
    ACT_CLEAR_ALL = 3'd4,
    ACT_FIND      = 3'd5
  } action_e;

  // Position of the lowest set bit; isolate it, then OR the positions together
  function automatic logic [POS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] iso;
    logic [POS_W-1:0] pos;
    iso = w & (~w + 32'd1);
    pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (iso[j]) begin
        pos = pos | POS_W'(j);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* hdl/bfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/bitmap_find_first_set.sv */
// Bitmap of 32-bit words with get, set, clear, fill and find-first-set actions.
//
// The bitmap lives in one RAM with a registered read; a valid bit per
// word in flip-flops makes every word read as zero after reset, so there is no
// clearing pass and the block takes words right out of reset. One input word
// yields one output word. Get, set and clear go through a read state to the done
// state; set-all and clear-all write each word in use in turn, and find reads
// words from the start word, one RAM read per cycle, at most 32, up to the first
// set bit or the last word in use (capped at the stored words). Unused actions,
// out-of-range bits and a find start beyond the words in use go straight to the
// done state. A new input word is taken as soon as the previous one has finished
// its work, even while its result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_find_first_set #(
  parameter int WORD_COUNT = bfs_pkg::DEFAULT_WORD_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input word: [2:0] action, [12:3] bit_index, [15:13] zero
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  // Output word: [0] bit_value, [1] found, [11:2] found_index, [15:12] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import bfs_pkg::*;

  // Words beyond the addressable range can never be observed
  localparam int STORE_WORDS = (WORD_COUNT < ADDRESSABLE_WORDS) ? WORD_COUNT
                                                                : ADDRESSABLE_WORDS;
  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [WIU_W-1:0] STORE_LIM = WIU_W'(STORE_WORDS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FILL,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  action_e                 act_q, act_d;
  logic [WORD_IDX_W-1:0]   word_q, word_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [WORD_IDX_W-1:0]   scan_q, scan_d;
  logic [WIU_W-1:0]        fill_q, fill_d;
  logic                    res_bit_q, res_bit_d;
  logic                    res_found_q, res_found_d;
  logic [IDX_W-1:0]        res_idx_q, res_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [15:0]             out_data_q, out_data_d;
  logic [WIU_W-1:0]        wiu_q;
  logic [STORE_WORDS-1:0]  valid_q;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]    ram_wdata, ram_rdata;

  logic                    accept;
  action_e                 in_act;
  logic [IDX_W-1:0]        in_idx;
  logic [WORD_IDX_W-1:0]   in_word;
  logic                    in_store;
  logic [WIU_W-1:0]        lim;
  logic [WORD_BITS-1:0]    word_val;
  logic [WORD_BITS-1:0]    masked;
  logic [WORD_BITS-1:0]    bit_mask;
  logic [WIU_W-1:0]        scan_next;
  logic [WIU_W-1:0]        fill_next;
  logic                    out_free;

  // Register port: one register, words in use
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, wiu_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q <= WIU_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      wiu_q <= pwdata[WIU_W-1:0];
    end
  end

  // Words covered by fill and find
  assign lim = (wiu_q > STORE_LIM) ? STORE_LIM : wiu_q;

  // Decode the input word
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_act   = action_e'(s_axis_tdata[ACT_W-1:0]);
  assign in_idx   = s_axis_tdata[ACT_W +: IDX_W];
  assign in_word  = in_idx[IDX_W-1:POS_W];
  assign in_store = {1'b0, in_word} < STORE_LIM;

  // Word read last cycle; a never-written word reads as zero
  assign word_val  = valid_q[scan_q[AW-1:0]] ? ram_rdata : '0;
  assign bit_mask  = WORD_BITS'(1) << pos_q;
  assign masked    = (scan_q == word_q) ? (word_val & (ALL_ONES << pos_q)) : word_val;
  assign scan_next = WIU_W'(scan_q) + WIU_W'(1);
  assign fill_next = fill_q + WIU_W'(1);
  assign out_free  = !out_valid_q || m_axis_tready;

  // Sequencer: read, modify, write back; accesses never overlap in time
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    word_d      = word_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    fill_d      = fill_q;
    res_bit_d   = res_bit_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = scan_q[AW-1:0];
    ram_wdata   = word_val;
    ram_re      = 1'b0;
    ram_raddr   = in_word[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d       = in_act;
          word_d      = in_word;
          pos_d       = in_idx[POS_W-1:0];
          scan_d      = in_word;
          fill_d      = '0;
          res_bit_d   = 1'b0;
          res_found_d = 1'b0;
          res_idx_d   = '0;
          ram_re      = in_store;
          case (in_act)
            ACT_GET, ACT_SET, ACT_CLEAR: begin
              state_d = in_store ? S_READ : S_DONE;
            end
            ACT_FIND: begin
              state_d = ({1'b0, in_word} < lim) ? S_READ : S_DONE;
            end
            ACT_SET_ALL, ACT_CLEAR_ALL: begin
              state_d = (lim != '0) ? S_FILL : S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        case (act_q)
          ACT_GET: begin
            res_bit_d = word_val[pos_q];
            state_d   = S_DONE;
          end
          ACT_SET: begin
            ram_we    = 1'b1;
            ram_wdata = word_val | bit_mask;
            state_d   = S_DONE;
          end
          ACT_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = word_val & ~bit_mask;
            state_d   = S_DONE;
          end
          ACT_FIND: begin
            if (masked != '0) begin
              res_found_d = 1'b1;
              res_idx_d   = {scan_q, lowest_set(masked)};
              state_d     = S_DONE;
            end else if (scan_next < lim) begin
              scan_d    = scan_next[WORD_IDX_W-1:0];
              ram_re    = 1'b1;
              ram_raddr = scan_next[AW-1:0];
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q[AW-1:0];
        ram_wdata = (act_q == ACT_SET_ALL) ? ALL_ONES : '0;
        if (fill_next >= lim) begin
          state_d = S_DONE;
        end else begin
          fill_d = fill_next;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'd0, res_idx_q, res_found_q, res_bit_q};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, operands, results and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_GET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    pos_q       <= pos_d;
    scan_q      <= scan_d;
    fill_q      <= fill_d;
    res_bit_q   <= res_bit_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_data_q  <= out_data_d;
  end

  // Mark a word valid once it has been written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  bfs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_bfs_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Fill sweep stays inside the words in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (fill_q < lim))
    else $error("fill sweep past words in use");

  // Find scan never goes below the start word or past the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && act_q == ACT_FIND) |-> (scan_q >= word_q && {1'b0, scan_q} < lim))
    else $error("find scan out of range");

  // Only a find reports a located bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_found_q) |-> (act_q == ACT_FIND))
    else $error("found flag without find");

  // A new result enters the output register only from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside done state");

endmodule

`default_nettype wire

/* test/bitmap_find_first_set_tb.sv */
// Testbench for bitmap_find_first_set: directed, configuration and randomized stream tests.
`timescale 1ns / 1ps

module bitmap_find_first_set_tb;
  import bfs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam logic [2:0] REG_WORDS_IN_USE = 3'd0;
  localparam int STORED_WORDS = DEFAULT_WORD_COUNT;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  // Result fields, highest bits first in the packed word
  typedef struct packed {
    logic [IDX_W-1:0] found_index;
    logic             found;
    logic             bit_value;
  } bfs_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the bitmap and of the words-in-use register
  logic [WORD_BITS-1:0] bitmap_shadow [STORED_WORDS];
  logic [WIU_W-1:0]     words_cfg;
  bfs_result_t          pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold_left;
  int mismatch_count;
  int quiet_cycles;

  bitmap_find_first_set dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one action to the shadow bitmap and return the result it must produce
  function automatic bfs_result_t apply_action(input logic [ACT_W-1:0] act,
                                               input logic [IDX_W-1:0] idx);
    bfs_result_t          res;
    int                   word;
    int                   limit;
    int                   low;
    logic [WORD_BITS-1:0] scan;
    res = '0;
    word = int'(idx[IDX_W-1:POS_W]);
    limit = (int'(words_cfg) > STORED_WORDS) ? STORED_WORDS : int'(words_cfg);
    if (limit > ADDRESSABLE_WORDS) limit = ADDRESSABLE_WORDS;
    case (act)
      ACT_GET: begin
        res.bit_value = bitmap_shadow[word][idx[POS_W-1:0]];
      end
      ACT_SET: begin
        bitmap_shadow[word][idx[POS_W-1:0]] = 1'b1;
      end
      ACT_CLEAR: begin
        bitmap_shadow[word][idx[POS_W-1:0]] = 1'b0;
      end
      ACT_SET_ALL, ACT_CLEAR_ALL: begin
        for (int w = 0; w < limit; w++) begin
          bitmap_shadow[w] = (act == ACT_SET_ALL) ? ALL_ONES : '0;
        end
      end
      ACT_FIND: begin
        // Mask the start word below the start bit, then walk up to the last word in use
        for (int w = word; w < limit; w++) begin
          scan = bitmap_shadow[w];
          if (w == word) scan = scan & (ALL_ONES << idx[POS_W-1:0]);
          if (!res.found && scan != '0) begin
            low = 0;
            for (int b = WORD_BITS - 1; b >= 0; b--) begin
              if (scan[b]) low = b;
            end
            res.found = 1'b1;
            res.found_index = IDX_W'(w * WORD_BITS + low);
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Offer one word, idling at random first, and record its result once accepted
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, idx, act};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_action(act, idx));
  endtask

  // Drop valid and hold until every result is back and the block has settled
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_words_in_use(input logic [WIU_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_WORDS_IN_USE;
    pwdata  <= {{(32 - WIU_W){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    words_cfg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    logic [IDX_W-1:0] idx;
    idx = IDX_W'($urandom_range(1023));
    case ($urandom_range(3))
      0: idx[POS_W-1:0] = '0;
      1: idx[POS_W-1:0] = '1;
      2: if (words_cfg != 0) begin
        idx[IDX_W-1:POS_W] = WORD_IDX_W'($urandom_range(int'(words_cfg) - 1) % 32);
      end
      default: begin
      end
    endcase
    return idx;
  endfunction

  // Weighted mix keeps the bitmap sparse so finds walk several words
  function automatic logic [ACT_W-1:0] pick_action();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return ACT_FIND;
    if (roll < 55) return ACT_SET;
    if (roll < 72) return ACT_CLEAR;
    if (roll < 85) return ACT_GET;
    if (roll < 89) return ACT_SET_ALL;
    if (roll < 96) return ACT_CLEAR_ALL;
    return ($urandom_range(1) != 0) ? ACT_SPARE_7 : ACT_SPARE_6;
  endfunction

  task automatic test_directed();
    send_word(ACT_FIND, 10'd0);       // empty bitmap: nothing found
    send_word(ACT_GET, 10'd0);
    send_word(ACT_SET, 10'd0);
    send_word(ACT_SET, 10'd31);
    send_word(ACT_SET, 10'd1023);
    send_word(ACT_GET, 10'd31);
    send_word(ACT_GET, 10'd1023);
    send_word(ACT_FIND, 10'd0);
    send_word(ACT_FIND, 10'd1);
    send_word(ACT_FIND, 10'd31);      // start on the top bit of a word
    send_word(ACT_FIND, 10'd32);
    send_word(ACT_FIND, 10'd1023);
    send_word(ACT_CLEAR, 10'd0);
    send_word(ACT_CLEAR, 10'd31);
    send_word(ACT_FIND, 10'd0);
    send_word(ACT_SPARE_6, 10'd1023);
    send_word(ACT_SPARE_7, 10'h155);
    send_word(ACT_SET_ALL, 10'd0);
    send_word(ACT_GET, 10'h2AA);
    send_word(ACT_FIND, 10'd777);
    send_word(ACT_CLEAR_ALL, 10'd1023);
    send_word(ACT_FIND, 10'd0);
    send_word(ACT_GET, 10'd1023);
    drain_results();
  endtask

  // Zero, one, full and beyond-storage word counts, each with fills and finds
  task automatic test_word_counts();
    logic [WIU_W-1:0] counts [4];
    counts = '{6'd0, 6'd1, 6'd63, 6'd32};
    foreach (counts[k]) begin
      write_words_in_use(counts[k]);
      send_word(ACT_SET_ALL, 10'd0);
      send_word(ACT_FIND, 10'd0);
      send_word(ACT_FIND, 10'd40);    // past the first word
      send_word(ACT_CLEAR_ALL, 10'd0);
      send_word(ACT_SET, 10'd1000);
      send_word(ACT_FIND, 10'd5);
      drain_results();
    end
  endtask

  task automatic test_random(input int items, input int idle_pct, input int stall_pct,
                             input logic [WIU_W-1:0] count);
    write_words_in_use(count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_word(pick_action(), pick_index());
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    write_words_in_use(6'd32);
    @(posedge clk_i);
    recv_hold_left = 300;
    repeat (30) send_word(pick_action(), pick_index());
    drain_results();
  endtask

  // Receiver readiness, with an optional long hold-off
  always @(negedge clk_i) begin
    if (recv_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold_left <= recv_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  // Compare each result word against the oldest pending prediction
  always @(posedge clk_i) begin
    bfs_result_t want;
    bfs_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[11:0];
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result word", 0, int'(m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.bit_value !== want.bit_value)
          note_mismatch("bit_value", int'(want.bit_value), int'(got.bit_value));
        if (got.found !== want.found)
          note_mismatch("found", int'(want.found), int'(got.found));
        if (got.found_index !== want.found_index)
          note_mismatch("found_index", int'(want.found_index), int'(got.found_index));
        if (m_axis_tdata[15:12] !== 4'b0000)
          note_mismatch("pad bits", 0, int'(m_axis_tdata[15:12]));
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    words_cfg      = WIU_RESET;
    foreach (bitmap_shadow[w]) bitmap_shadow[w] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_word_counts();
    test_random(230, 0, 0, 6'd32);
    test_random(230, 60, 0, WIU_W'($urandom_range(1, 32)));
    test_random(230, 0, 60, WIU_W'($urandom_range(1, 32)));
    test_random(200, 26, 26, 6'd32);
    test_backpressure();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bfs_pkg.sv
hdl/bfs_ram.sv
hdl/bitmap_find_first_set.sv
test/bitmap_find_first_set_tb.sv
